// File: hw/rtl/rc5pd_pkg.sv
// ----------------------------------------------------------------------------
// rc5pd_pkg
// Shared types and constants of the RC5 pulse frame decoder.
// ----------------------------------------------------------------------------
package rc5pd_pkg;

  localparam int DURATION_WIDTH_DEF = 16;

  localparam int HALF_WIDTH      = 16;
  localparam int PCT_WIDTH       = 7;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 16;

  localparam logic [HALF_WIDTH-1:0] HALF_RESET = 16'd889;
  localparam logic [PCT_WIDTH-1:0]  PCT_RESET  = 7'd30;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_HALF_PERIOD = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TOLERANCE   = 2'd1;

  // half * pct, then divide by 100 through a reciprocal multiply
  localparam int PROD_WIDTH  = HALF_WIDTH + PCT_WIDTH;
  localparam int RECIP_WIDTH = 24;
  localparam int RECIP_SHIFT = 30;
  localparam logic [RECIP_WIDTH-1:0] RECIP_MUL = 24'd10737419;
  localparam int TOL_WIDTH   = 17;
  localparam int BOUND_WIDTH = 18;
  localparam logic [1:0] SETTLE_CYCLES = 2'd3;

  localparam int POS_WIDTH   = 5;
  localparam int BIT_COUNT   = 14;
  localparam int ADDR_WIDTH  = 5;
  localparam int CMD_WIDTH   = 6;
  localparam logic [POS_WIDTH-1:0] PULSES_MIN = 5'd26;
  localparam logic [POS_WIDTH-1:0] PULSES_MAX = 5'd27;

  typedef struct packed {
    logic [BOUND_WIDTH-1:0] lo;
    logic [BOUND_WIDTH-1:0] hi;
  } window_t;

endpackage

// File: hw/rtl/rc5pd_window.sv
// ----------------------------------------------------------------------------
// rc5pd_window
// Configuration registers and the registered computation of the accepted
// duration window [half - tol, half + tol].
// ----------------------------------------------------------------------------
module rc5pd_window import rc5pd_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  output window_t                    win,
  output logic                       busy
);

  logic [HALF_WIDTH-1:0] half;
  logic [PCT_WIDTH-1:0]  pct;
  logic [1:0]            settle;
  logic [PROD_WIDTH-1:0] prod;
  logic [TOL_WIDTH-1:0]  tol;
  logic [PROD_WIDTH+RECIP_WIDTH-1:0] quot_full;

  assign cfg_ready = 1'b1;
  assign busy      = (settle != 2'd0);
  assign quot_full = {{RECIP_WIDTH{1'b0}}, prod} * {{PROD_WIDTH{1'b0}}, RECIP_MUL};

  always_ff @(posedge clk) begin
    if (rst) begin
      half   <= HALF_RESET;
      pct    <= PCT_RESET;
      settle <= SETTLE_CYCLES;
    end else begin
      if (cfg_valid) begin
        settle <= SETTLE_CYCLES;
        unique case (cfg_index)
          REG_HALF_PERIOD: half <= cfg_data[HALF_WIDTH-1:0];
          REG_TOLERANCE:   pct  <= cfg_data[PCT_WIDTH-1:0];
          default: ;
        endcase
      end else if (settle != 2'd0) begin
        settle <= settle - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod   <= {{PCT_WIDTH{1'b0}}, half} * {{HALF_WIDTH{1'b0}}, pct};
    tol    <= quot_full[RECIP_SHIFT +: TOL_WIDTH];
    win.hi <= {2'b00, half} + {1'b0, tol};
    win.lo <= ({1'b0, half} > tol) ? {2'b00, half - tol[HALF_WIDTH-1:0]}
                                   : '0;
  end

endmodule

// File: hw/rtl/rc5pd_step.sv
// ----------------------------------------------------------------------------
// rc5pd_step
// Per-pulse Manchester and duration checks, frame state and result register.
// ----------------------------------------------------------------------------
module rc5pd_step import rc5pd_pkg::*; #(
  parameter int DURATION_WIDTH = DURATION_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      take,
  input  logic [DURATION_WIDTH-1:0] p_dur,
  input  logic                      p_lvl,
  input  logic                      p_fend,
  input  window_t                   win,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      status,
  output logic [ADDR_WIDTH-1:0]     address,
  output logic [CMD_WIDTH-1:0]      command
);

  localparam int CW = (DURATION_WIDTH > BOUND_WIDTH) ? DURATION_WIDTH : BOUND_WIDTH;

  logic [POS_WIDTH-1:0] pos, pos_next;
  logic                 fail, fail_next;
  logic                 fhl, fhl_next;
  logic [BIT_COUNT-1:0] shift, shift_next;
  logic [BIT_COUNT-1:0] bits;
  logic [CW-1:0]        dext;
  logic                 d_ok;
  logic                 good;

  always_comb begin
    dext       = CW'(p_dur);
    d_ok       = (dext >= CW'(win.lo)) && (dext <= CW'(win.hi));
    pos_next   = pos;
    fail_next  = fail;
    fhl_next   = fhl;
    shift_next = shift;
    if (pos < PULSES_MAX) begin
      if ((pos < PULSES_MIN) && !d_ok) fail_next = 1'b1;
      if (pos == '0) begin
        shift_next = {{(BIT_COUNT-1){1'b0}}, p_lvl};
      end else if (pos[0]) begin
        fhl_next = p_lvl;
      end else begin
        if (fhl == p_lvl) fail_next = 1'b1;
        shift_next = {shift[BIT_COUNT-2:0], p_lvl};
      end
      pos_next = pos + 5'd1;
    end
    // 26-pulse frame: last bit is a 0
    bits = (pos_next == PULSES_MIN) ? {shift_next[BIT_COUNT-2:0], 1'b0} : shift_next;
    good = !fail_next && (pos_next >= PULSES_MIN) &&
           (bits[BIT_COUNT-1:BIT_COUNT-2] == 2'b11);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      fail      <= 1'b0;
      fhl       <= 1'b0;
      shift     <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= (out_valid && !out_ready) || (take && p_fend);
      if (take) begin
        if (p_fend) begin
          pos   <= '0;
          fail  <= 1'b0;
          fhl   <= 1'b0;
          shift <= '0;
        end else begin
          pos   <= pos_next;
          fail  <= fail_next;
          fhl   <= fhl_next;
          shift <= shift_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && p_fend) begin
      status  <= !good;
      address <= good ? bits[CMD_WIDTH +: ADDR_WIDTH] : '0;
      command <= good ? bits[CMD_WIDTH-1:0] : '0;
    end
  end

endmodule

// File: hw/rtl/rc5_pulse_frame_decoder.sv
// ----------------------------------------------------------------------------
// rc5_pulse_frame_decoder
// RC5 infrared frame decoder working on captured pulses.
// ----------------------------------------------------------------------------
// One pulse request is taken per clock cycle when nothing stalls the input; a
// pulse passes an input register and then the check logic into the result
// register. Only a frame end pulse waits while an earlier result is still
// unclaimed. After reset and after every configuration write the input is
// held off while the duration window is recomputed (multiply, reciprocal
// divide by 100, bounds).
// ----------------------------------------------------------------------------
module rc5_pulse_frame_decoder import rc5pd_pkg::*; #(
  parameter int DURATION_WIDTH = DURATION_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [DURATION_WIDTH-1:0]  duration,
  input  logic                       level,
  input  logic                       frame_end,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       status,
  output logic [ADDR_WIDTH-1:0]      address,
  output logic [CMD_WIDTH-1:0]       command
);

  window_t                   win;
  logic                      busy;
  logic                      p_valid;
  logic [DURATION_WIDTH-1:0] p_dur;
  logic                      p_lvl;
  logic                      p_fend;
  logic                      advance;
  logic                      take;

  assign advance  = !(p_fend && out_valid && !out_ready);
  assign take     = p_valid && advance;
  assign in_ready = !busy && (!p_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      p_valid <= 1'b1;
    end else if (take) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      p_dur  <= duration;
      p_lvl  <= level;
      p_fend <= frame_end;
    end
  end

  rc5pd_window u_window (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .win       (win),
    .busy      (busy)
  );

  rc5pd_step #(.DURATION_WIDTH(DURATION_WIDTH)) u_step (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .p_dur     (p_dur),
    .p_lvl     (p_lvl),
    .p_fend    (p_fend),
    .win       (win),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .address   (address),
    .command   (command)
  );

endmodule

// File: hw/rtl/rc5pd_checker.sv
// ----------------------------------------------------------------------------
// rc5pd_checker
// Port-level assertions for the RC5 pulse frame decoder, bound to the top.
// ----------------------------------------------------------------------------
module rc5pd_checker import rc5pd_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  status,
  input logic [ADDR_WIDTH-1:0] address,
  input logic [CMD_WIDTH-1:0]  command
);

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (address == '0 && command == '0))
    else $error("failed frame reports nonzero fields");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(status) && $stable(address) && $stable(command)))
    else $error("stalled result request changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result request after reset");

  a_cfg_holdoff: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> !in_ready)
    else $error("pulse taken while window recomputes");

endmodule

bind rc5_pulse_frame_decoder rc5pd_checker u_checker (.*);

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the RC5 pulse frame decoder.
// ----------------------------------------------------------------------------
// Captured pulses are fed one request at a time as encoded RC5 frames. A
// directed table comes first, run at the reset window: window edges, field
// extremes, Manchester and start bit errors, short, 26-pulse and overlong
// frames. Random phases follow, each under its own half period and tolerance,
// extremes included. The phases mix well-formed frames, corrupted frames and
// noise. A local decoder tracks every accepted pulse and queues the result it
// expects at each frame end, or the table's own result for checked rows. The
// sender works in bursts and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb;
  import rc5pd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500000;
  localparam int N_DIR       = 20;
  localparam int N_PHASES    = 8;
  localparam int NONE        = -1;
  localparam int AUTO_DUR    = -1;

  typedef struct packed {
    logic                  status;
    logic [ADDR_WIDTH-1:0] address;
    logic [CMD_WIDTH-1:0]  command;
  } result_t;

  typedef struct packed {
    logic [15:0] dur;
    logic        lvl;
    logic        fend;
    logic        checked;
    result_t     want;
  } pulse_t;

  typedef struct packed {
    logic [BIT_COUNT-1:0] bits;
    int                   npulses;
    int                   dur;
    int                   odd_pos;
    int                   odd_dur;
    int                   flip_pos;
    logic                 checked;
    result_t              want;
  } frame_row_t;

  typedef enum int {READY_ALWAYS, READY_RANDOM, READY_SPARSE, READY_TOGGLE} ready_mode_t;

  localparam result_t NO_FRAME = '{1'b1, 5'd0, 6'd0};
  localparam result_t UNTYPED  = '{1'b0, 5'd0, 6'd0};

  // reset window: 889 +/- 266, i.e. 623..1155
  frame_row_t dir_rows [N_DIR] = '{
    '{14'b11_1_10101_110011, 27, 889,  NONE, NONE,  NONE, 1'b1, '{1'b0, 5'd21, 6'd51}},
    '{14'b11_1_11111_111111, 27, 623,  NONE, NONE,  NONE, 1'b1, '{1'b0, 5'd31, 6'd63}},
    '{14'b11_0_00000_000000, 27, 1155, NONE, NONE,  NONE, 1'b1, '{1'b0, 5'd0, 6'd0}},
    '{14'b11_0_01010_101010, 27, 889,  5,    622,   NONE, 1'b1, NO_FRAME},
    '{14'b11_0_01010_101010, 27, 889,  25,   1156,  NONE, 1'b1, NO_FRAME},
    '{14'b11_1_00111_011100, 27, 889,  26,   65535, NONE, 1'b1, '{1'b0, 5'd7, 6'd28}},
    '{14'b11_0_10110_011001, 27, 889,  26,   0,     NONE, 1'b0, UNTYPED},
    '{14'b11_1_00111_011100, 27, 889,  0,    0,     NONE, 1'b1, NO_FRAME},
    '{14'b11_1_00111_011100, 27, 889,  12,   65535, NONE, 1'b1, NO_FRAME},
    '{14'b11_0_01010_101010, 27, 889,  NONE, NONE,  13,   1'b1, NO_FRAME},
    '{14'b11_0_01010_101010, 27, 889,  NONE, NONE,  26,   1'b1, NO_FRAME},
    '{14'b11_0_01010_101010, 27, 889,  NONE, NONE,  0,    1'b1, NO_FRAME},
    '{14'b11_0_00011_000101, 26, 889,  NONE, NONE,  NONE, 1'b1, '{1'b0, 5'd3, 6'd4}},
    '{14'b11_1_11111_111111, 25, 889,  NONE, NONE,  NONE, 1'b1, NO_FRAME},
    '{14'b11_1_10000_000001, 31, 889,  NONE, NONE,  NONE, 1'b1, '{1'b0, 5'd16, 6'd1}},
    '{14'b10_0_11000_110000, 27, 889,  NONE, NONE,  NONE, 1'b1, NO_FRAME},
    '{14'b01_1_11000_110000, 27, 889,  NONE, NONE,  NONE, 1'b1, NO_FRAME},
    '{14'b11_1_11111_111111, 1,  889,  NONE, NONE,  NONE, 1'b1, NO_FRAME},
    '{14'b11_0_00011_000101, 26, 889,  25,   1156,  NONE, 1'b1, NO_FRAME},
    '{14'b11_1_01101_100110, 27, AUTO_DUR, NONE, NONE, NONE, 1'b0, UNTYPED}
  };

  int unsigned phase_half [N_PHASES] = '{1, 65535, 65535, 0, 1, 889, 0, 0};
  int unsigned phase_pct  [N_PHASES] = '{0, 100, 127, 0, 100, 30, 0, 0};

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_HALF_PERIOD;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [15:0]                duration = '0;
  logic                       level = 1'b0;
  logic                       frame_end = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       status;
  logic [ADDR_WIDTH-1:0]      address;
  logic [CMD_WIDTH-1:0]       command;

  rc5_pulse_frame_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .duration    (duration),
    .level       (level),
    .frame_end   (frame_end),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .address     (address),
    .command     (command)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // decoder copy
  logic [15:0]          half_reg = HALF_RESET;
  logic [6:0]           pct_reg  = PCT_RESET;
  int unsigned          rx_pos;
  logic                 rx_failed;
  logic                 rx_half_lvl;
  logic [BIT_COUNT-1:0] rx_bits;

  pulse_t      pulse_feed [$];
  result_t     frames_due [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  function automatic void window_bounds(output int unsigned lo, output int unsigned hi);
    int unsigned h;
    int unsigned tol;
    h   = half_reg;
    tol = (h * pct_reg) / 100;
    lo  = (h > tol) ? h - tol : 0;
    hi  = h + tol;
  endfunction

  function automatic logic [15:0] rand_in_window();
    int unsigned lo;
    int unsigned hi;
    int unsigned sel;
    window_bounds(lo, hi);
    if (hi > 65535) hi = 65535;
    sel = $urandom_range(7, 0);
    if (sel == 0) return lo[15:0];
    if (sel == 1) return hi[15:0];
    return 16'($urandom_range(hi, lo));
  endfunction

  function automatic logic [15:0] rand_outside();
    int unsigned lo;
    int unsigned hi;
    window_bounds(lo, hi);
    if (lo == 0 && hi >= 65535) return 16'($urandom_range(65535, 0));
    if (lo > 0 && (hi >= 65535 || $urandom_range(1, 0) == 1)) begin
      if ($urandom_range(1, 0) == 1) return 16'(lo - 1);
      return 16'($urandom_range(lo - 1, 0));
    end
    if ($urandom_range(1, 0) == 1) return 16'(hi + 1);
    return 16'($urandom_range(65535, hi + 1));
  endfunction

  function automatic void clear_track();
    rx_pos      = 0;
    rx_failed   = 1'b0;
    rx_half_lvl = 1'b0;
    rx_bits     = '0;
  endfunction

  function automatic void decode_pulse(input pulse_t p, output bit got, output result_t r);
    int unsigned lo;
    int unsigned hi;
    logic [BIT_COUNT-1:0] b;
    logic ok;
    got = 1'b0;
    r   = '0;
    if (rx_pos < PULSES_MAX) begin
      window_bounds(lo, hi);
      if (rx_pos < PULSES_MIN && (p.dur < lo || p.dur > hi)) rx_failed = 1'b1;
      if (rx_pos == 0) begin
        rx_bits = {{(BIT_COUNT-1){1'b0}}, p.lvl};
      end else if (rx_pos % 2 == 1) begin
        rx_half_lvl = p.lvl;
      end else begin
        if (rx_half_lvl == p.lvl) rx_failed = 1'b1;
        rx_bits = {rx_bits[BIT_COUNT-2:0], p.lvl};
      end
      rx_pos++;
    end
    if (p.fend) begin
      b  = rx_bits;
      ok = !rx_failed && rx_pos >= PULSES_MIN;
      if (rx_pos == PULSES_MIN) b = {b[BIT_COUNT-2:0], 1'b0};
      if (b[13:12] != 2'b11) ok = 1'b0;
      got       = 1'b1;
      r.status  = !ok;
      r.address = ok ? b[10:6] : '0;
      r.command = ok ? b[5:0] : '0;
      clear_track();
    end
  endfunction

  // bit b of the frame sits at v[13-b]; pulse 0 is bit 0's second half,
  // odd pulses are first halves (inverted), even pulses second halves
  task automatic push_frame(input logic [BIT_COUNT-1:0] v, input int n, input int dur,
                            input int odd_pos, input int odd_dur, input int flip_pos,
                            input logic checked, input result_t want);
    pulse_t p;
    int b;
    for (int k = 0; k < n; k++) begin
      if (k >= PULSES_MAX) begin
        p.dur = 16'($urandom_range(65535, 0));
        p.lvl = 1'($urandom_range(1, 0));
      end else begin
        b     = (k + 1) / 2;
        p.lvl = (k % 2 == 1) ? ~v[13-b] : v[13-b];
        if (k == flip_pos) p.lvl = ~p.lvl;
        if (k == odd_pos) p.dur = 16'(odd_dur);
        else if (dur >= 0) p.dur = 16'(dur);
        else p.dur = rand_in_window();
      end
      p.fend    = (k == n - 1);
      p.checked = checked && p.fend;
      p.want    = want;
      pulse_feed.push_back(p);
    end
  endtask

  task automatic run_random_phase();
    int unsigned pulses;
    int unsigned frames;
    int unsigned kind;
    int n;
    logic [BIT_COUNT-1:0] v;
    pulse_t p;
    pulses = 0;
    frames = 0;
    while (pulses < 40 || frames < 2) begin
      v        = 14'($urandom);
      v[13:12] = 2'b11;
      kind     = $urandom_range(99, 0);
      n        = 27;
      if (kind < 55) begin
        push_frame(v, n, AUTO_DUR, NONE, NONE, NONE, 1'b0, UNTYPED);
      end else if (kind < 65) begin
        n = 26;
        push_frame(v, n, AUTO_DUR, NONE, NONE, NONE, 1'b0, UNTYPED);
      end else if (kind < 72) begin
        n = $urandom_range(34, 28);
        push_frame(v, n, AUTO_DUR, NONE, NONE, NONE, 1'b0, UNTYPED);
      end else if (kind < 80) begin
        n = $urandom_range(27, 26);
        push_frame(v, n, AUTO_DUR, $urandom_range(n - 1, 0), rand_outside(), NONE,
                   1'b0, UNTYPED);
      end else if (kind < 85) begin
        push_frame(v, n, AUTO_DUR, NONE, NONE, $urandom_range(26, 0), 1'b0, UNTYPED);
      end else if (kind < 90) begin
        v = 14'($urandom);
        push_frame(v, n, AUTO_DUR, NONE, NONE, NONE, 1'b0, UNTYPED);
      end else if (kind < 95) begin
        n = $urandom_range(25, 1);
        push_frame(v, n, AUTO_DUR, NONE, NONE, NONE, 1'b0, UNTYPED);
      end else begin
        n = $urandom_range(40, 1);
        for (int k = 0; k < n; k++) begin
          p.dur     = ($urandom_range(1, 0) == 1) ? rand_in_window()
                                                 : 16'($urandom_range(65535, 0));
          p.lvl     = 1'($urandom_range(1, 0));
          p.fend    = (k == n - 1);
          p.checked = 1'b0;
          p.want    = UNTYPED;
          pulse_feed.push_back(p);
        end
      end
      pulses += n;
      frames++;
    end
  endtask

  task automatic set_window(input logic [15:0] half, input logic [6:0] pct);
    cfg_valid <= 1'b1;
    cfg_index <= REG_HALF_PERIOD;
    cfg_data  <= half;
    do @(posedge clk); while (!cfg_ready);
    half_reg = half;
    cfg_index <= REG_TOLERANCE;
    cfg_data  <= {9'($urandom_range(511, 0)), pct};
    do @(posedge clk); while (!cfg_ready);
    pct_reg = pct;
    cfg_valid <= 1'b0;
  endtask

  // results drained and in-flight pulses settled
  task automatic await_quiet();
    do @(negedge clk); while (pulse_feed.size() != 0 || in_valid || frames_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // pulse sender, bursts with gaps
  pulse_t cur_pulse;
  int     burst_left = 0;
  int     gap_left = 0;

  always @(posedge clk) begin : feed
    bit      got;
    result_t r;
    if (rst) begin
      in_valid <= 1'b0;
      clear_track();
    end else begin
      if (in_valid && in_ready) begin
        decode_pulse(cur_pulse, got, r);
        if (got) frames_due.push_back(cur_pulse.checked ? cur_pulse.want : r);
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || pulse_feed.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          cur_pulse = pulse_feed.pop_front();
          in_valid    <= 1'b1;
          duration    <= cur_pulse.dur;
          level       <= cur_pulse.lvl;
          frame_end   <= cur_pulse.fend;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(40, 0);
            gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
          end
        end
      end
    end
  end

  // result sink stall patterns
  ready_mode_t ready_mode = READY_ALWAYS;
  int          ready_left = 0;

  always @(posedge clk) begin : drain
    if (ready_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(3, 0));
      ready_left = $urandom_range(160, 16);
    end else begin
      ready_left--;
    end
    case (ready_mode)
      READY_ALWAYS: out_ready <= 1'b1;
      READY_RANDOM: out_ready <= 1'($urandom_range(1, 0));
      READY_SPARSE: out_ready <= ($urandom_range(4, 0) == 0);
      default:      out_ready <= ~out_ready;
    endcase
  end

  always @(posedge clk) begin : check
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (frames_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0b address=%0d command=%0d",
                                  status, address, command));
      end else begin
        want = frames_due.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0b, want %0b", status, want.status));
        if (address !== want.address)
          report_mismatch($sformatf("address %0d, want %0d", address, want.address));
        if (command !== want.command)
          report_mismatch($sformatf("command %0d, want %0d", command, want.command));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("rc5_pulse_frame_decoder regression: fail");
      $finish;
    end
  end

  initial begin : run
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    for (int k = 0; k < N_DIR; k++)
      push_frame(dir_rows[k].bits, dir_rows[k].npulses, dir_rows[k].dur, dir_rows[k].odd_pos,
                 dir_rows[k].odd_dur, dir_rows[k].flip_pos, dir_rows[k].checked,
                 dir_rows[k].want);
    await_quiet();
    for (int k = 0; k < N_PHASES; k++) begin
      if (k >= 6) begin
        phase_half[k] = $urandom_range(3000, 200);
        phase_pct[k]  = $urandom_range(127, 0);
      end
      set_window(16'(phase_half[k]), 7'(phase_pct[k]));
      run_random_phase();
      await_quiet();
    end
    repeat (8) @(posedge clk);
    if (frames_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", frames_due.size()));
    if (mismatches == 0) begin
      $display("rc5_pulse_frame_decoder regression: pass");
    end else begin
      $display("rc5_pulse_frame_decoder regression: fail");
    end
    $finish;
  end

endmodule
